### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL of the segment box core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared constants and types of the segment box containment core.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

  localparam int DEF_COORD_BITS    = 24;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int CFG_IDX_W         = 3;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X     = 3'd0,
    CFG_BOX_MIN_Y     = 3'd1,
    CFG_BOX_MIN_Z     = 3'd2,
    CFG_BOX_MAX_X     = 3'd3,
    CFG_BOX_MAX_Y     = 3'd4,
    CFG_BOX_MAX_Z     = 3'd5,
    CFG_THRESHOLD     = 3'd6
  } cfg_reg_t;

  // Per-axis face flags that travel beside the dividers.
  typedef struct packed {
    logic [2:0] active;     // axis has non-zero displacement
    logic [2:0] lead_neg;   // start is beyond the face it moves toward
    logic [2:0] trail_pos;  // entering face lies ahead of the start
  } face_flags_t;

endpackage

`default_nettype wire

### hw/rtl/sbc_in_if.sv
// ----------------------------------------------------------------------------
// sbc_in_if
// Segment transaction channel: valid/ready with start and end points.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbc_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

// ----------------------------------------------------------------------------
// sbc_out_if
// Result transaction channel: valid/ready with fraction and flags.
// ----------------------------------------------------------------------------
interface sbc_out_if #(
  parameter int FRACTION_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [FRACTION_BITS:0] inside_fraction;
  logic                   is_contained;
  logic                   zero_length;
  logic                   forced_outside;

  modport source (output valid, inside_fraction, is_contained, zero_length,
                  forced_outside, input ready);
  modport sink   (input valid, inside_fraction, is_contained, zero_length,
                  forced_outside, output ready);
endinterface

`default_nettype wire

### hw/rtl/sbc_ratio_pipe.sv
// ----------------------------------------------------------------------------
// sbc_ratio_pipe
// Pipelined restoring divider: num/den in Q1.FW, saturating at 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_ratio_pipe #(
  parameter int CW = 24,
  parameter int FW = 16
) (
  input  wire logic          clk,
  input  wire logic [FW:0]   adv,
  input  wire logic [CW:0]   num,
  input  wire logic [CW:0]   den,
  output      logic [FW:0]   ratio
);

  localparam int NW = CW + 1;

  logic [NW-1:0] rem_r [FW+1];
  logic [NW-1:0] den_r [FW+1];
  logic          sat_r [FW+1];
  logic [FW-1:0] q_r   [FW+1];

  // Entry stage: latch operands and decide saturation.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      sat_r[0] <= (num >= den);
      q_r[0]   <= '0;
    end
  end

  // One quotient bit per stage.
  for (genvar j = 1; j <= FW; j++) begin : g_bit
    logic [NW:0] sh;
    logic [NW:0] diff;
    logic        ge;

    assign sh   = {rem_r[j-1], 1'b0};
    assign diff = sh - {1'b0, den_r[j-1]};
    assign ge   = (sh >= {1'b0, den_r[j-1]});

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        rem_r[j] <= ge ? diff[NW-1:0] : sh[NW-1:0];
        den_r[j] <= den_r[j-1];
        sat_r[j] <= sat_r[j-1];
        q_r[j]   <= {q_r[j-1][FW-2:0], ge};
      end
    end
  end

  assign ratio = sat_r[FW] ? {1'b1, {FW{1'b0}}} : {1'b0, q_r[FW]};

endmodule

`default_nettype wire

### hw/rtl/segment_box_containment_core.sv
// ----------------------------------------------------------------------------
// segment_box_containment_core
// Slab clip of a 3D segment against a configured axis-aligned box.
//
// Throughput is one transaction per cycle unless the result channel stalls;
// the six dividers are pipelined with one quotient bit per stage, which
// sets the depth. Reset is synchronous and active low: it empties the
// pipeline, clears the box faces to 0 and sets the threshold to 0.9.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module segment_box_containment_core #(
  parameter int COORD_BITS    = sbc_pkg::DEF_COORD_BITS,
  parameter int FRACTION_BITS = sbc_pkg::DEF_FRACTION_BITS,
  parameter int CFG_DATA_BITS = (COORD_BITS > FRACTION_BITS + 1) ?
                                COORD_BITS : FRACTION_BITS + 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  sbc_in_if.sink                              in_ch,
  sbc_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [sbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]       cfg_wdata
);

  import sbc_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int FW  = FRACTION_BITS;
  localparam int NST = FW + 4;   // prep, FW+1 divider stages, combine, output
  localparam int CS  = FW + 2;   // combine stage index
  localparam int OS  = FW + 3;   // output register stage index
  localparam logic [FW:0] FRAC_ONE   = {1'b1, {FW{1'b0}}};
  localparam logic [FW:0] THR_RESET  = (FW + 1)'((9 * (64'd1 << FW)) / 10);

  // Config regs (unguarded): software must write only while the core is idle.
  logic signed [CW-1:0] box_lo_r [3];
  logic signed [CW-1:0] box_hi_r [3];
  logic [FW:0]          thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        box_lo_r[a] <= '0;
        box_hi_r[a] <= '0;
      end
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BOX_MIN_X: box_lo_r[0] <= cfg_wdata[CW-1:0];
        CFG_BOX_MIN_Y: box_lo_r[1] <= cfg_wdata[CW-1:0];
        CFG_BOX_MIN_Z: box_lo_r[2] <= cfg_wdata[CW-1:0];
        CFG_BOX_MAX_X: box_hi_r[0] <= cfg_wdata[CW-1:0];
        CFG_BOX_MAX_Y: box_hi_r[1] <= cfg_wdata[CW-1:0];
        CFG_BOX_MAX_Z: box_hi_r[2] <= cfg_wdata[CW-1:0];
        CFG_THRESHOLD: thr_r       <= cfg_wdata[FW:0];
        default: ;  // Writes beyond the register map are dropped.
      endcase
    end
  end

  // Pipeline flow control. Each stage holds a valid bit and loads whenever it
  // is empty or its contents move on, so bubbles collapse under a stall and
  // input is taken while the result register waits, until the pipeline fills.
  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ch.ready = adv[0];

  // Prep stage: per axis, the displacement, its magnitude as the divisor,
  // and the distances from the start to the leaving and entering faces.
  logic signed [CW-1:0] st [3];
  logic signed [CW-1:0] en [3];

  assign st[0] = in_ch.start_x;
  assign st[1] = in_ch.start_y;
  assign st[2] = in_ch.start_z;
  assign en[0] = in_ch.end_x;
  assign en[1] = in_ch.end_y;
  assign en[2] = in_ch.end_z;

  logic [CW:0]  den_nxt   [3];
  logic [CW:0]  lead_nxt  [3];
  logic [CW:0]  trail_nxt [3];
  face_flags_t  flags_nxt;

  always_comb begin
    logic signed [CW:0] s_e;
    logic signed [CW:0] d;
    logic signed [CW:0] lead;
    logic signed [CW:0] trail;
    logic               pos;
    for (int a = 0; a < 3; a++) begin
      s_e   = (CW+1)'(st[a]);
      d     = (CW+1)'(en[a]) - s_e;
      pos   = !d[CW];
      lead  = pos ? (CW+1)'(box_hi_r[a]) - s_e : s_e - (CW+1)'(box_lo_r[a]);
      trail = pos ? (CW+1)'(box_lo_r[a]) - s_e : s_e - (CW+1)'(box_hi_r[a]);
      den_nxt[a]             = pos ? d : -d;
      lead_nxt[a]            = lead;
      trail_nxt[a]           = trail;
      flags_nxt.active[a]    = (d != '0);
      flags_nxt.lead_neg[a]  = lead[CW];
      flags_nxt.trail_pos[a] = !trail[CW] && (trail != '0);
    end
  end

  logic [CW:0]  den_r   [3];
  logic [CW:0]  lead_r  [3];
  logic [CW:0]  trail_r [3];
  face_flags_t  flags_r [CS];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      den_r      <= den_nxt;
      lead_r     <= lead_nxt;
      trail_r    <= trail_nxt;
      flags_r[0] <= flags_nxt;
    end
    for (int k = 1; k < CS; k++) begin
      if (adv[k]) begin
        flags_r[k] <= flags_r[k-1];
      end
    end
  end

  // Six crossing parameters, one divider per face.
  logic [FW:0] t_lead  [3];
  logic [FW:0] t_trail [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    sbc_ratio_pipe #(.CW(CW), .FW(FW)) u_lead (
      .clk   (clk),
      .adv   (adv[FW+1:1]),
      .num   (lead_r[a]),
      .den   (den_r[a]),
      .ratio (t_lead[a])
    );
    sbc_ratio_pipe #(.CW(CW), .FW(FW)) u_trail (
      .clk   (clk),
      .adv   (adv[FW+1:1]),
      .num   (trail_r[a]),
      .den   (den_r[a]),
      .ratio (t_trail[a])
    );
  end

  // Combine stage: tightest exit over the leaving faces, latest entry over
  // the entering faces, plus the forced and zero-length flags.
  face_flags_t fl;
  logic [FW:0] t_out_nxt;
  logic [FW:0] t_in_nxt;

  assign fl = flags_r[CS-1];

  always_comb begin
    t_out_nxt = FRAC_ONE;
    t_in_nxt  = '0;
    for (int a = 0; a < 3; a++) begin
      if (fl.active[a] && !fl.lead_neg[a] && (t_lead[a] < t_out_nxt)) begin
        t_out_nxt = t_lead[a];
      end
      if (fl.active[a] && fl.trail_pos[a] && (t_trail[a] > t_in_nxt)) begin
        t_in_nxt = t_trail[a];
      end
    end
  end

  logic [FW:0] t_out_r;
  logic [FW:0] t_in_r;
  logic        forced_r;
  logic        zero_r;

  always_ff @(posedge clk) begin
    if (adv[CS]) begin
      t_out_r  <= t_out_nxt;
      t_in_r   <= t_in_nxt;
      forced_r <= |(fl.active & fl.lead_neg);
      zero_r   <= !(|fl.active);
    end
  end

  // Output stage: the clipped fraction and the threshold compare.
  logic [FW:0] frac_nxt;
  logic [FW:0] frac_r;
  logic        contained_r;
  logic        zero_out_r;
  logic        forced_out_r;

  assign frac_nxt = (!zero_r && !forced_r && (t_out_r > t_in_r)) ?
                    (t_out_r - t_in_r) : '0;

  always_ff @(posedge clk) begin
    if (adv[OS]) begin
      frac_r       <= frac_nxt;
      contained_r  <= (frac_nxt >= thr_r);
      zero_out_r   <= zero_r;
      forced_out_r <= forced_r && !zero_r;
    end
  end

  assign out_ch.valid           = v_r[OS];
  assign out_ch.inside_fraction = frac_r;
  assign out_ch.is_contained    = contained_r;
  assign out_ch.zero_length     = zero_out_r;
  assign out_ch.forced_outside  = forced_out_r;

  // A zero-length segment reports no fraction and no forced exit.
  `SBC_ASSERT_NOW(a_zero_clean, clk, rst_n,
    out_ch.valid && out_ch.zero_length,
    out_ch.inside_fraction == '0 && !out_ch.forced_outside,
    "zero-length result carries a fraction or forced flag")

  // A forced exit always yields an empty fraction.
  `SBC_ASSERT_NOW(a_forced_empty, clk, rst_n,
    out_ch.valid && out_ch.forced_outside,
    out_ch.inside_fraction == '0,
    "forced-outside result carries a non-zero fraction")

  // The fraction never exceeds one.
  `SBC_ASSERT_NOW(a_frac_range, clk, rst_n,
    out_ch.valid,
    out_ch.inside_fraction <= FRAC_ONE,
    "inside fraction above 1.0")

  // A stalled result is held valid until it is taken.
  `SBC_ASSERT_NEXT(a_stall_holds, clk, rst_n,
    out_ch.valid && !out_ch.ready,
    out_ch.valid,
    "pending result dropped during stall")

endmodule

`default_nettype wire

### tb/tb_segment_box_containment_core.sv
// ----------------------------------------------------------------------------
// tb_segment_box_containment_core
// Self-checking bench for the segment box containment core. Segments stream
// through the valid/ready channels; each accepted segment is clipped against
// the current box by a local slab-clip predictor and compared with the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_segment_box_containment_core;
  import sbc_pkg::*;

  localparam int CB = DEF_COORD_BITS;
  localparam int FB = DEF_FRACTION_BITS;
  localparam int DW = (CB > FB + 1) ? CB : FB + 1;
  localparam int LATENCY = FB + 4;
  localparam int STALL_LIMIT = 5000;
  localparam logic [FB:0] FRAC_ONE = {1'b1, {FB{1'b0}}};

  typedef struct packed {
    logic signed [CB-1:0] sx, sy, sz, ex, ey, ez;
  } segment_t;

  typedef struct packed {
    logic [FB:0] fraction;
    logic        contained;
    logic        zero_len;
    logic        forced;
  } clip_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_wdata = '0;

  sbc_in_if #(.COORD_BITS(CB)) in_ch ();
  sbc_out_if #(.FRACTION_BITS(FB)) out_ch ();

  segment_box_containment_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Box and threshold as the predictor sees them.
  logic signed [CB-1:0] box_lo [3];
  logic signed [CB-1:0] box_hi [3];
  logic [FB:0] threshold;

  segment_t pending_segments[$];
  clip_result_t expected_clips[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_receiver = 1'b0;
  int mismatches = 0;
  int stall_cycles = 0;

  initial forever #5 clk = ~clk;

  // Crossing parameter num/den in Q1.FB, saturating at one.
  function automatic logic [FB:0] crossing(longint num, longint den);
    if (num >= den) return FRAC_ONE;
    return (FB+1)'((num << FB) / den);
  endfunction

  function automatic clip_result_t clip_segment(segment_t s);
    clip_result_t r;
    longint st [3];
    longint en [3];
    longint d, lead, trail, den;
    logic [FB:0] t_in, t_out, t;
    bit forced, zero;
    st[0] = s.sx; st[1] = s.sy; st[2] = s.sz;
    en[0] = s.ex; en[1] = s.ey; en[2] = s.ez;
    t_in = '0; t_out = FRAC_ONE; forced = 0; zero = 1;
    for (int a = 0; a < 3; a++) begin
      d = en[a] - st[a];
      if (d == 0) continue;
      zero = 0;
      if (d > 0) begin
        den = d; lead = longint'(box_hi[a]) - st[a]; trail = longint'(box_lo[a]) - st[a];
      end else begin
        den = -d; lead = st[a] - longint'(box_lo[a]); trail = st[a] - longint'(box_hi[a]);
      end
      if (lead < 0) forced = 1;
      else begin
        t = crossing(lead, den);
        if (t < t_out) t_out = t;
      end
      if (trail > 0) begin
        t = crossing(trail, den);
        if (t > t_in) t_in = t;
      end
    end
    r.fraction = '0;
    if (zero) forced = 0;
    else if (!forced && t_out > t_in) r.fraction = t_out - t_in;
    r.contained = (r.fraction >= threshold);
    r.zero_len = zero;
    r.forced = forced;
    return r;
  endfunction

  // Driver: the valid stays up until the transaction is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid)
        expected_clips = {expected_clips, clip_segment(pending_segments.pop_front())};
      if (pending_segments.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        {in_ch.start_x, in_ch.start_y, in_ch.start_z, in_ch.end_x, in_ch.end_y, in_ch.end_z}
          <= pending_segments[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    clip_result_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.inside_fraction, out_ch.is_contained, out_ch.zero_length,
                out_ch.forced_outside};
        if (expected_clips.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
        end else begin
          want = expected_clips.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Result mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      out_ch.ready <= !hold_receiver && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      stall_cycles <= 0;
    else if (pending_segments.size() > 0 || expected_clips.size() > 0)
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL segment_box_containment_core");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [DW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BOX_MIN_X, CFG_BOX_MIN_Y, CFG_BOX_MIN_Z: box_lo[int'(idx)] = value[CB-1:0];
      CFG_BOX_MAX_X, CFG_BOX_MAX_Y, CFG_BOX_MAX_Z: box_hi[int'(idx) - 3] = value[CB-1:0];
      CFG_THRESHOLD: threshold = value[FB:0];
      default: ;
    endcase
  endtask

  task automatic set_box(int lo, int hi, int thr);
    write_reg(CFG_BOX_MIN_X, DW'(lo));
    write_reg(CFG_BOX_MIN_Y, DW'(lo));
    write_reg(CFG_BOX_MIN_Z, DW'(lo));
    write_reg(CFG_BOX_MAX_X, DW'(hi));
    write_reg(CFG_BOX_MAX_Y, DW'(hi));
    write_reg(CFG_BOX_MAX_Z, DW'(hi));
    write_reg(CFG_THRESHOLD, DW'(thr));
  endtask

  task automatic drain();
    while (pending_segments.size() > 0 || expected_clips.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Appends one segment to the pending queue of the driver.
  task automatic add_segment(longint sx, longint sy, longint sz,
                             longint ex, longint ey, longint ez);
    segment_t s;
    s.sx = CB'(sx); s.sy = CB'(sy); s.sz = CB'(sz);
    s.ex = CB'(ex); s.ey = CB'(ey); s.ez = CB'(ez);
    pending_segments = {pending_segments, s};
  endtask

  function automatic logic signed [CB-1:0] rand_coord(int span);
    if ($urandom_range(9) == 0) return CB'($urandom);
    return CB'($signed($urandom_range(2 * span)) - span);
  endfunction

  // Mostly short segments near the box so that clipping is exercised; some
  // full-range noise covers every bit of the coordinates.
  task automatic queue_random(int count, int span);
    segment_t s;
    for (int i = 0; i < count; i++) begin
      s.sx = rand_coord(span); s.sy = rand_coord(span); s.sz = rand_coord(span);
      case ($urandom_range(3))
        0: begin s.ex = s.sx; s.ey = rand_coord(span); s.ez = s.sz; end
        1: begin s.ex = s.sx; s.ey = s.sy; s.ez = s.sz; end
        default: begin s.ex = rand_coord(span); s.ey = rand_coord(span); s.ez = rand_coord(span); end
      endcase
      pending_segments = {pending_segments, s};
    end
  endtask

  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    box_lo = '{default: '0}; box_hi = '{default: '0}; threshold = (FB+1)'(58982);
    in_ch.valid = 1'b0;
    {in_ch.start_x, in_ch.start_y, in_ch.start_z, in_ch.end_x, in_ch.end_y, in_ch.end_z} = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed segments against the reset box (a single point) then a real box.
    add_segment(0, 0, 0, 0, 0, 0);
    add_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    add_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    drain();
    set_box(-100, 100, 65536);
    add_segment(-200, 0, 0, 200, 0, 0);     // half inside
    add_segment(0, 0, 0, 50, 0, 0);         // fully inside
    add_segment(100, 0, 0, 200, 0, 0);      // starts on leaving face
    add_segment(150, 0, 0, 300, 0, 0);      // beyond leaving face
    add_segment(-300, 0, 0, -150, 0, 0);    // ends before the box
    add_segment(-150, 0, 0, -100, 0, 0);    // entry exactly at end
    add_segment(7, 7, 7, 7, 7, 7);          // zero length
    add_segment(-100, -100, -100, 100, 100, 100);
    add_segment(-50, 200, 0, 50, -200, 3);
    add_segment(CMAX, 0, 0, CMIN, 0, 0);
    drain();
    write_reg(CFG_THRESHOLD, DW'(0));
    add_segment(-200, 0, 0, 200, 0, 0);
    drain();
    set_box(100, -100, 58982);                             // inverted box
    add_segment(-200, 0, 0, 200, 0, 0);
    add_segment(0, 0, 0, 1, 1, 1);
    drain();

    // Random phases with differing idling and boxes.
    set_box(-1000, 1000, 32768);
    send_idle_pct = 33; recv_idle_pct = 46;
    queue_random(250, 3000);
    drain();
    set_box(CMIN, CMAX, 65536);
    write_reg(CFG_BOX_MIN_Y, DW'(-5)); write_reg(CFG_BOX_MAX_Z, DW'(40000));
    send_idle_pct = 46; recv_idle_pct = 33;
    queue_random(250, 60000);
    drain();
    set_box(-20, 300, 1);
    send_idle_pct = 0; recv_idle_pct = 0;
    queue_random(330, 500);
    // Hold the receiver off long enough that the pipeline fills and stalls input.
    hold_receiver = 1'b1;
    repeat (200) @(posedge clk);
    hold_receiver = 1'b0;
    drain();

    if (mismatches == 0)
      $display("PASS segment_box_containment_core");
    else
      $display("FAIL segment_box_containment_core");
    $finish;
  end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_in_if.sv
hw/rtl/sbc_ratio_pipe.sv
hw/rtl/segment_box_containment_core.sv
tb/tb_segment_box_containment_core.sv
